@@ design/longest_window_k_distinct_defines.svh @@
// Assertion macros for the design module.
`ifndef LONGEST_WINDOW_K_DISTINCT_DEFINES_SVH
`define LONGEST_WINDOW_K_DISTINCT_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define LWKD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define LWKD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/lwkd_pkg.sv @@
// Package for the longest window with at most K distinct symbols.
package lwkd_pkg;

  localparam int unsigned SYMBOL_W        = 8;
  localparam int unsigned NUM_SYMBOLS     = 256;
  localparam int unsigned DISTINCT_W      = 9;
  localparam int unsigned BEST_LENGTH_W   = 11;
  localparam int unsigned BEST_START_W    = 10;
  localparam int unsigned MAX_LEN_DEFAULT = 1024;

  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  localparam logic [DISTINCT_W-1:0] MAX_DISTINCT_RESET = DISTINCT_W'(2);

  // Register index, taken from paddr[2].
  localparam logic REG_MAX_DISTINCT = 1'b0;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INC,
    S_EVB,
    S_EVC,
    S_DONE
  } state_t;

endpackage

@@ design/lwkd_if.sv @@
// Handshake channels for input symbols and results.
interface lwkd_in_if;
  import lwkd_pkg::*;
  logic                valid;
  logic                ready;
  logic [SYMBOL_W-1:0] symbol;
  logic                last;

  modport source (output valid, output symbol, output last, input ready);
  modport sink (input valid, input symbol, input last, output ready);
endinterface

interface lwkd_out_if;
  import lwkd_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [BEST_LENGTH_W-1:0] best_length;
  logic [BEST_START_W-1:0]  best_start;
  logic                     overflow;

  modport source (output valid, output best_length, output best_start, output overflow,
                  input ready);
  modport sink (input valid, input best_length, input best_start, input overflow,
                output ready);
endinterface

@@ design/longest_window_k_distinct.sv @@
// A symbol is taken in S_IDLE, which reads its count, and S_INC writes the count back; each
//   symbol it evicts adds S_EVB, a count read, and S_EVC, a write back. A new symbol waits
//   for S_IDLE; every insert and eviction does a count read, then modify and write back.
// A last symbol leads to S_DONE, which loads the result register; the result waits there.
// Reset (synchronous, active high) clears the window state, the count valid bits and the
//   output valid flag, and sets max_distinct to 2; no clearing pass is needed.
module longest_window_k_distinct #(
  parameter int unsigned MAX_LEN = lwkd_pkg::MAX_LEN_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  lwkd_in_if.sink                     symbols,
  lwkd_out_if.source                  results,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lwkd_pkg::PADDR_W-1:0] paddr,
  input  logic [lwkd_pkg::PDATA_W-1:0] pwdata,
  output logic [lwkd_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import lwkd_pkg::*;

`include "longest_window_k_distinct_defines.svh"

  // PW holds a position up to MAX_LEN; AW indexes the window store.
  localparam int unsigned PW = $clog2(MAX_LEN + 1);
  localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam logic [PW-1:0] FULL = PW'(MAX_LEN);

  // Memories: per-symbol occurrence counts and the symbols of the window.
  logic [PW-1:0]       count_mem [NUM_SYMBOLS];
  logic [SYMBOL_W-1:0] store_mem [MAX_LEN];

  state_t state, state_next;

  logic [DISTINCT_W-1:0]  max_distinct;
  logic [NUM_SYMBOLS-1:0] count_valid;
  logic                   cur_last;
  logic [PW-1:0]          position;
  logic [PW-1:0]          left_edge;
  logic [DISTINCT_W-1:0]  distinct_count;
  logic [PW-1:0]          longest_length;
  logic [AW-1:0]          longest_start;
  logic                   overflowed;
  logic [SYMBOL_W-1:0]    cnt_addr;
  logic [PW-1:0]          cnt_rdata;
  logic [SYMBOL_W-1:0]    store_rdata;

  logic                     out_valid;
  logic [BEST_LENGTH_W-1:0] out_length;
  logic [BEST_START_W-1:0]  out_start;
  logic                     out_overflow;

  // Combinational controls.
  logic                  accept;
  logic                  full;
  logic                  out_free;
  logic [PW-1:0]         cnt_cur;
  logic [PW-1:0]         pos_inc;
  logic [DISTINCT_W-1:0] dist_inc;
  logic                  evict_start;
  logic [PW-1:0]         left_dec;
  logic [DISTINCT_W-1:0] dist_dec;
  logic                  evict_more;
  logic                  finish;
  logic [PW-1:0]         win_pos;
  logic [PW-1:0]         win_left;
  logic [PW-1:0]         win_len;
  logic                  better;
  logic                  cnt_re;
  logic [SYMBOL_W-1:0]   cnt_raddr;
  logic                  cnt_we;
  logic [PW-1:0]         cnt_wdata;
  logic                  store_re;
  logic [AW-1:0]         store_raddr;
  logic                  store_we;
  logic                  cfg_write;

  // Configuration port: one register, max_distinct, at byte address 0.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_MAX_DISTINCT);
  assign prdata    = (paddr[2] == REG_MAX_DISTINCT) ? PDATA_W'(max_distinct) : '0;

  // The block takes a symbol only when it sits idle; the result register is separate,
  // so a new string may start while the previous result still waits.
  assign symbols.ready = (state == S_IDLE);
  assign accept        = symbols.valid && symbols.ready;
  assign full          = (position == FULL);
  assign out_free      = !out_valid || results.ready;

  // A count entry that was not written since the last clear reads as zero.
  assign cnt_cur = count_valid[cnt_addr] ? cnt_rdata : '0;

  // Insert: the new symbol joins the window.
  assign pos_inc     = position + PW'(1);
  assign dist_inc    = distinct_count + DISTINCT_W'(cnt_cur == '0);
  assign evict_start = (dist_inc > max_distinct);

  // Evict: the oldest symbol leaves the window.
  assign left_dec   = left_edge + PW'(1);
  assign dist_dec   = distinct_count - DISTINCT_W'(cnt_cur == PW'(1));
  assign evict_more = (dist_dec > max_distinct) && (left_dec < position);

  // Window bounds once the symbol has settled; only a strictly longer window wins.
  always_comb begin
    win_pos  = position;
    win_left = left_edge;
    finish   = 1'b0;
    if (state == S_INC) begin
      win_pos = pos_inc;
      finish  = !evict_start;
    end else if (state == S_EVC) begin
      win_left = left_dec;
      finish   = !evict_more;
    end
  end
  assign win_len = win_pos - win_left;
  assign better  = finish && (win_len > longest_length);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (!full) state_next = S_INC;
          else if (symbols.last) state_next = S_DONE;
        end
      end
      S_INC: begin
        if (evict_start) state_next = S_EVB;
        else state_next = cur_last ? S_DONE : S_IDLE;
      end
      S_EVB: state_next = S_EVC;
      S_EVC: begin
        if (evict_more) state_next = S_EVB;
        else state_next = cur_last ? S_DONE : S_IDLE;
      end
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Memory controls per state.
  always_comb begin
    cnt_re      = 1'b0;
    cnt_raddr   = symbols.symbol;
    cnt_we      = 1'b0;
    cnt_wdata   = cnt_cur + PW'(1);
    store_re    = 1'b0;
    store_raddr = left_edge[AW-1:0];
    store_we    = 1'b0;
    case (state)
      S_IDLE: begin
        // Read the count of the new symbol and put the symbol in the store.
        cnt_re   = accept && !full;
        store_we = accept && !full;
      end
      S_INC: begin
        // Write back the incremented count; fetch the oldest symbol if over the limit.
        cnt_we   = 1'b1;
        store_re = evict_start;
      end
      S_EVB: begin
        // Read the count of the symbol that leaves.
        cnt_re    = 1'b1;
        cnt_raddr = store_rdata;
      end
      S_EVC: begin
        // Write back the decremented count; fetch the next oldest symbol if needed.
        cnt_we      = 1'b1;
        cnt_wdata   = cnt_cur - PW'(cnt_cur != '0);
        store_re    = evict_more;
        store_raddr = left_dec[AW-1:0];
      end
      S_DONE: begin
        cnt_re = 1'b0;
      end
      default: begin
        cnt_re = 1'b0;
      end
    endcase
  end

  // Count memory: read data registered, write at the latched address.
  always_ff @(posedge clk) begin
    if (cnt_we) count_mem[cnt_addr] <= cnt_wdata;
    if (cnt_re) cnt_rdata <= count_mem[cnt_raddr];
  end

  // Window store.
  always_ff @(posedge clk) begin
    if (store_we) store_mem[position[AW-1:0]] <= symbols.symbol;
    if (store_re) store_rdata <= store_mem[store_raddr];
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cnt_re) cnt_addr <= cnt_raddr;
    if (accept) cur_last <= symbols.last;
    if (state == S_DONE && out_free) begin
      out_length   <= BEST_LENGTH_W'(longest_length);
      out_start    <= (longest_length == '0) ? '0 : BEST_START_W'(longest_start);
      out_overflow <= overflowed;
    end
  end

  // Control and window state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      max_distinct   <= MAX_DISTINCT_RESET;
      count_valid    <= '0;
      position       <= '0;
      left_edge      <= '0;
      distinct_count <= '0;
      longest_length <= '0;
      longest_start  <= '0;
      overflowed     <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) max_distinct <= pwdata[DISTINCT_W-1:0];

      if (accept && full) overflowed <= 1'b1;
      if (cnt_we) count_valid[cnt_addr] <= 1'b1;

      if (state == S_INC) begin
        position       <= pos_inc;
        distinct_count <= dist_inc;
      end
      if (state == S_EVC) begin
        left_edge      <= left_dec;
        distinct_count <= dist_dec;
      end
      if (better) begin
        longest_length <= win_len;
        longest_start  <= win_left[AW-1:0];
      end

      // Load a new result and clear the string state, else drop the taken result.
      if (state == S_DONE && out_free) begin
        out_valid      <= 1'b1;
        count_valid    <= '0;
        position       <= '0;
        left_edge      <= '0;
        distinct_count <= '0;
        longest_length <= '0;
        longest_start  <= '0;
        overflowed     <= 1'b0;
      end else if (out_valid && results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign results.valid       = out_valid;
  assign results.best_length = out_length;
  assign results.best_start  = out_start;
  assign results.overflow    = out_overflow;

  `LWKD_ASSERT_NOW(a_left_in_window, 1'b1, left_edge <= position,
                   "left edge passed the position")
  `LWKD_ASSERT_NOW(a_distinct_fits, 1'b1,
                   PW'(distinct_count) <= position - left_edge || distinct_count == '0,
                   "distinct count exceeds window length")
  `LWKD_ASSERT_NOW(a_evict_over_limit, state == S_EVB, distinct_count > max_distinct,
                   "eviction while within the distinct limit")
  `LWKD_ASSERT_NEXT(a_clear_after_result, state == S_DONE && out_free,
                    position == '0 && distinct_count == '0 && count_valid == '0,
                    "string state not cleared after the result")

endmodule

@@ test/longest_window_k_distinct_tb.sv @@
// Self-checking testbench: directed and random strings checked against a window predictor.
module longest_window_k_distinct_tb;
  import lwkd_pkg::*;

  localparam int unsigned CAPACITY       = MAX_LEN_DEFAULT;
  localparam int unsigned CLK_HALF       = 4;
  // A symbol may evict the whole window, each eviction a count read and a write back.
  localparam int unsigned SETTLE_CYCLES  = 2 * CAPACITY + 8;
  localparam int unsigned DRAIN_LIMIT    = 50000;
  localparam int unsigned TIMEOUT_CYCLES = 600000;
  localparam logic [PADDR_W-1:0] MAX_DISTINCT_ADDR = {REG_MAX_DISTINCT, 2'b00};

  typedef struct packed {
    logic [BEST_LENGTH_W-1:0] best_length;
    logic [BEST_START_W-1:0]  best_start;
    logic                     overflow;
  } window_result_t;

  // Predictor of the sliding window plus the queue of results still owed by the block.
  class window_scoreboard;
    logic [DISTINCT_W-1:0] max_distinct;
    int unsigned           counts[NUM_SYMBOLS];
    logic [SYMBOL_W-1:0]   store[CAPACITY];
    int unsigned           fill;
    int unsigned           left_edge;
    int unsigned           distinct;
    int unsigned           best_len;
    int unsigned           best_start;
    bit                    truncated;
    window_result_t        owed[$];
    int unsigned           errors;
    int unsigned           strings_done;
    int unsigned           results_ok;

    function new();
      max_distinct = MAX_DISTINCT_RESET;
      errors       = 0;
      strings_done = 0;
      results_ok   = 0;
      foreach (store[i]) store[i] = '0;
      clear_string();
    endfunction

    function void clear_string();
      foreach (counts[i]) counts[i] = 0;
      fill       = 0;
      left_edge  = 0;
      distinct   = 0;
      best_len   = 0;
      best_start = 0;
      truncated  = 1'b0;
    endfunction

    task report(input string what);
      $display("[%0t] mismatch: %s", $time, what);
      errors++;
    endtask

    // Advance the window by one accepted symbol; owe a result on the last one.
    function void note_symbol(input logic [SYMBOL_W-1:0] sym, input logic last);
      logic [SYMBOL_W-1:0] oldest;
      window_result_t      res;
      if (fill < CAPACITY) begin
        store[fill] = sym;
        if (counts[sym] == 0) distinct++;
        counts[sym]++;
        fill++;
        while (distinct > max_distinct && left_edge < fill) begin
          oldest = store[left_edge];
          if (counts[oldest] > 0) begin
            counts[oldest]--;
            if (counts[oldest] == 0) distinct--;
          end
          left_edge++;
        end
        // Strictly longer only, so the earliest longest window is kept.
        if (fill - left_edge > best_len) begin
          best_len   = fill - left_edge;
          best_start = left_edge;
        end
      end else begin
        truncated = 1'b1;
      end
      if (last) begin
        res.best_length = BEST_LENGTH_W'(best_len);
        res.best_start  = (best_len == 0) ? '0 : BEST_START_W'(best_start);
        res.overflow    = truncated;
        owed.push_back(res);
        strings_done++;
        clear_string();
      end
    endfunction

    task check_result(input window_result_t got);
      window_result_t want;
      bit             good;
      if (owed.size() == 0) begin
        report($sformatf("result with none owed: length %0d start %0d overflow %0b",
                         got.best_length, got.best_start, got.overflow));
        return;
      end
      want = owed.pop_front();
      good = 1'b1;
      if (got.best_length !== want.best_length) begin
        report($sformatf("best_length %0d, predicted %0d", got.best_length,
                         want.best_length));
        good = 1'b0;
      end
      if (got.best_start !== want.best_start) begin
        report($sformatf("best_start %0d, predicted %0d", got.best_start, want.best_start));
        good = 1'b0;
      end
      if (got.overflow !== want.overflow) begin
        report($sformatf("overflow %0b, predicted %0b", got.overflow, want.overflow));
        good = 1'b0;
      end
      if (good) results_ok++;
    endtask
  endclass

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  lwkd_in_if  sym_ch ();
  lwkd_out_if res_ch ();

  window_scoreboard board;

  // Idle odds in percent per cycle for each side, and a long receiver hold-off on request.
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned stall_request;
  int unsigned symbols_sent;
  int unsigned settings_used;

  longest_window_k_distinct u_dut (
    .clk     (clk),
    .rst     (rst),
    .symbols (sym_ch),
    .results (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    clk = 1'b0;
    #CLK_HALF;
    clk = 1'b1;
    #CLK_HALF;
  end

  // Offer one symbol, idling first at random; return at the falling edge after acceptance.
  task automatic send_item(input logic [SYMBOL_W-1:0] sym, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      sym_ch.valid <= 1'b0;
      @(negedge clk);
    end
    sym_ch.valid  <= 1'b1;
    sym_ch.symbol <= sym;
    sym_ch.last   <= last;
    do @(posedge clk); while (!(sym_ch.valid && sym_ch.ready));
    board.note_symbol(sym, last);
    symbols_sent++;
    @(negedge clk);
  endtask

  // Send count bytes, most significant first; the lowest byte carries the last mark.
  task automatic send_packed(input logic [63:0] bytes, input int unsigned count);
    for (int unsigned i = count; i > 0; i--) send_item(bytes[8*i-1 -: 8], i == 1);
  endtask

  // Draw from a small alphabet so the distinct limit bites; zero size means any byte.
  task automatic send_random_string(input int unsigned len, input int unsigned alpha_size);
    logic [SYMBOL_W-1:0] alphabet[8];
    foreach (alphabet[i]) alphabet[i] = SYMBOL_W'($urandom);
    for (int unsigned i = 0; i < len; i++) begin
      if (alpha_size == 0) send_item(SYMBOL_W'($urandom), i == len - 1);
      else send_item(alphabet[$urandom_range(alpha_size - 1)], i == len - 1);
    end
  endtask

  // Drop valid and hold until every owed result is in; optionally let the block settle.
  task automatic wait_results(input bit settle);
    sym_ch.valid <= 1'b0;
    while (board.owed.size() != 0) @(negedge clk);
    if (settle) repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write max_distinct through setup and access cycles, then read it back.
  task automatic write_max_distinct(input int unsigned value);
    wait_results(1'b1);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= MAX_DISTINCT_ADDR;
    pwdata  <= PDATA_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    board.max_distinct = DISTINCT_W'(value);
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== PDATA_W'(board.max_distinct))
      board.report($sformatf("max_distinct reads %0d, written %0d", prdata, value));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    settings_used++;
  endtask

  // Random strings: mostly short, a few long, now and then over the full byte range.
  task automatic random_strings(input int unsigned k, input int unsigned n_items);
    int unsigned first;
    int unsigned len;
    int unsigned alpha;
    write_max_distinct(k);
    first = symbols_sent;
    while (symbols_sent - first < n_items) begin
      len   = ($urandom_range(99) < 10) ? $urandom_range(25, 120) : $urandom_range(1, 24);
      alpha = ($urandom_range(99) < 15) ? 0 : $urandom_range(1, 8);
      send_random_string(len, alpha);
    end
  endtask

  // Result side: check at the rising edge, pick ready at the falling edge.
  initial begin : result_sink
    int unsigned    hold_left;
    window_result_t got;
    hold_left    = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_ch.valid && res_ch.ready) begin
        got.best_length = res_ch.best_length;
        got.best_start  = res_ch.best_start;
        got.overflow    = res_ch.overflow;
        board.check_result(got);
      end
      @(negedge clk);
      if (stall_request != 0) begin
        hold_left     = stall_request;
        stall_request = 0;
      end
      if (hold_left != 0) begin
        res_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin : watchdog
    #(TIMEOUT_CYCLES * 2 * CLK_HALF);
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    int unsigned waited;
    board          = new();
    rst            = 1'b1;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    sym_ch.valid   = 1'b0;
    sym_ch.symbol  = '0;
    sym_ch.last    = 1'b0;
    stall_request  = 0;
    symbols_sent   = 0;
    settings_used  = 0;
    send_idle_pct  = 13;
    recv_idle_pct  = 75;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: reset limit of two, with a tie that must keep the earlier window and
    // symbols that toggle every bit.
    send_packed(64'h00FF00AAAA55, 6);
    // One-symbol string.
    send_packed(64'h81, 1);
    // Zero limit: every symbol leaves at once, so length and start are zero.
    write_max_distinct(0);
    send_packed(64'h123412, 3);
    // Limit above the symbol count: the whole string qualifies.
    write_max_distinct(511);
    send_packed(64'h01020304F0, 5);
    // Limit of one: the best window lies later in the string.
    write_max_distinct(1);
    send_packed(64'h7E7E7F7F7F, 5);

    // Slow receiver.
    random_strings(1, 120);
    random_strings(3, 120);

    // Slow sender.
    send_idle_pct = 75;
    recv_idle_pct = 13;
    random_strings(0, 50);
    random_strings(5, 110);

    // No idling: fill the block against a held-off receiver, then pause the sender.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_max_distinct(4);
    stall_request = 600;
    repeat (12) send_random_string($urandom_range(2, 5), $urandom_range(1, 3));
    wait_results(1'b0);
    random_strings(2, 60);

    // Overlong string at the top of the symbol range: the window caps at capacity and
    // the last mark falls on a dropped symbol.
    write_max_distinct(NUM_SYMBOLS);
    send_random_string(CAPACITY + 3, 0);

    // Hold for the tail of results, bounded, then let the block settle.
    sym_ch.valid <= 1'b0;
    waited = 0;
    while (board.owed.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (board.owed.size() != 0)
      board.report($sformatf("%0d results never arrived", board.owed.size()));

    $display("Run: %0d symbols in %0d strings, %0d results matched, %0d limit settings",
             symbols_sent, board.strings_done, board.results_ok, settings_used);
    $display("Covered limits 0, 1 to 5, 256 and 511, a receiver hold-off and truncation.");
    if (board.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
